[rtl/rtac_pkg.sv]
// ----------------------------------------------------------------------------
// rtac_pkg: range triggered avoid controller package
// Item types, item kind codes, motor command codes, register indexes and
// fixed constants shared by the controller.
// ----------------------------------------------------------------------------
package rtac_pkg;

    // Item kind codes
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    // Motor command codes
    localparam logic [1:0] MOTOR_NONE   = 2'd0;
    localparam logic [1:0] MOTOR_NORMAL = 2'd1;
    localparam logic [1:0] MOTOR_CAP    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_POLL_DIVIDE     = 3'd0;
    localparam logic [2:0] REG_COMM_ERROR_LIM  = 3'd1;
    localparam logic [2:0] REG_NO_DATA_LIM     = 3'd2;
    localparam logic [2:0] REG_ENTER_SAMPLES   = 3'd3;
    localparam logic [2:0] REG_EXIT_SAMPLES    = 3'd4;
    localparam logic [2:0] REG_TRIGGER_MIN     = 3'd5;
    localparam logic [2:0] REG_TRIGGER_MAX     = 3'd6;
    localparam logic [2:0] REG_LEFT_LANE_LIMIT = 3'd7;

    // Distance constants
    localparam logic [13:0] NO_DIST  = 14'd8192;
    localparam logic [15:0] MAX_DIST = 16'd4000;

    // Input item
    typedef struct packed {
        logic [1:0]  kind;
        logic        comm_ok;
        logic        data_ready;
        logic        range_done;
        logic [15:0] range_mm;
        logic        motor_stopped;
        logic [7:0]  left_lost_rows;
        logic [7:0]  right_lost_rows;
        logic [7:0]  left_edge;
        logic [7:0]  right_edge;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              avoiding;
        logic signed [7:0] path_bias;
        logic              bias_written;
        logic [1:0]        motor_cmd;
        logic              reinit_request;
        logic              sample_taken;
        logic              range_valid;
        logic [13:0]       last_distance;
        logic              bypass_left;
        logic              sensor_ready;
    } t_out_item;

endpackage

[rtl/range_triggered_avoid_controller_core.sv]
// ----------------------------------------------------------------------------
// range_triggered_avoid_controller_core
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle unless the output stalls a held result;
// an item's state updates are one combinational pass into the state and
// result registers. Reset (synchronous, active low) loads register defaults,
// sets the controller state to its defaults and empties the output register.
// ----------------------------------------------------------------------------
module range_triggered_avoid_controller_core
    import rtac_pkg::*;
#(
    parameter int BIAS_PX     = 20,
    parameter int IMAGE_WIDTH = 188,
    parameter int VISION_ROW  = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam logic [7:0]        EDGE_RIGHT_MAX = 8'(IMAGE_WIDTH - 1);
    localparam logic [7:0]        ROW_LIMIT      = 8'(VISION_ROW);
    localparam logic signed [7:0] BIAS_POS       = 8'(BIAS_PX);
    localparam logic signed [7:0] BIAS_NEG       = 8'(-BIAS_PX);

    // configuration registers
    logic [7:0]  r_poll_divide, r_comm_error_limit, r_no_data_limit;
    logic [7:0]  r_enter_samples, r_exit_samples, r_left_lane_limit;
    logic [11:0] r_trigger_min, r_trigger_max;

    // controller state
    logic        r_ready_flag, n_ready_flag;
    logic        r_avoid_mode, n_avoid_mode;
    logic        r_left_chosen, n_left_chosen;
    logic        r_valid_flag, n_valid_flag;
    logic [7:0]  r_poll_count, n_poll_count;
    logic [7:0]  r_comm_err_count, n_comm_err_count;
    logic [7:0]  r_no_data_count, n_no_data_count;
    logic [7:0]  r_enter_count, n_enter_count;
    logic [7:0]  r_exit_count, n_exit_count;
    logic [13:0] r_held_distance, n_held_distance;

    // result register
    logic        r_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic        in_accept;
    logic [8:0]  lane_sum;
    logic [7:0]  lane_mid;
    logic [7:0]  poll_inc;
    logic        in_window;

    // handshakes: result register frees when taken
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // datapath terms computed ahead of the item case
    assign lane_sum    = {1'b0, i_in_item.left_edge} + {1'b0, i_in_item.right_edge};
    assign lane_mid    = lane_sum[8:1];
    assign poll_inc    = r_poll_count + 8'd1;
    assign in_window   = (i_in_item.range_mm >= {4'd0, r_trigger_min}) &&
                         (i_in_item.range_mm <= {4'd0, r_trigger_max});

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_divide      <= 8'd2;
            r_comm_error_limit <= 8'd5;
            r_no_data_limit    <= 8'd10;
            r_enter_samples    <= 8'd3;
            r_exit_samples     <= 8'd3;
            r_trigger_min      <= 12'd100;
            r_trigger_max      <= 12'd600;
            r_left_lane_limit  <= 8'd84;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POLL_DIVIDE:     r_poll_divide      <= i_cfg_data[7:0];
                REG_COMM_ERROR_LIM:  r_comm_error_limit <= i_cfg_data[7:0];
                REG_NO_DATA_LIM:     r_no_data_limit    <= i_cfg_data[7:0];
                REG_ENTER_SAMPLES:   r_enter_samples    <= i_cfg_data[7:0];
                REG_EXIT_SAMPLES:    r_exit_samples     <= i_cfg_data[7:0];
                REG_TRIGGER_MIN:     r_trigger_min      <= i_cfg_data;
                REG_TRIGGER_MAX:     r_trigger_max      <= i_cfg_data;
                REG_LEFT_LANE_LIMIT: r_left_lane_limit  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item processing: next state and result
    always_comb begin
        logic              bias_w, reinit, sample;
        logic signed [7:0] bias;
        logic [1:0]        motor;

        n_ready_flag     = r_ready_flag;
        n_avoid_mode     = r_avoid_mode;
        n_left_chosen    = r_left_chosen;
        n_valid_flag     = r_valid_flag;
        n_poll_count     = r_poll_count;
        n_comm_err_count = r_comm_err_count;
        n_no_data_count  = r_no_data_count;
        n_enter_count    = r_enter_count;
        n_exit_count     = r_exit_count;
        n_held_distance  = r_held_distance;
        bias_w = 1'b0;
        reinit = 1'b0;
        sample = 1'b0;
        bias   = '0;
        motor  = MOTOR_NONE;

        case (i_in_item.kind)
            // init: clear everything, ready follows start result
            KIND_INIT: begin
                n_ready_flag     = i_in_item.comm_ok;
                n_avoid_mode     = 1'b0;
                n_left_chosen    = 1'b0;
                n_valid_flag     = 1'b0;
                n_poll_count     = r_poll_divide - 8'd1;
                n_comm_err_count = '0;
                n_no_data_count  = '0;
                n_enter_count    = '0;
                n_exit_count     = '0;
                n_held_distance  = NO_DIST;
            end
            // frame: bypass side selection while following
            KIND_FRAME: begin
                if (r_ready_flag && !r_avoid_mode) begin
                    n_left_chosen = 1'b0;
                    if (!(ROW_LIMIT <= i_in_item.left_lost_rows ||
                          ROW_LIMIT <= i_in_item.right_lost_rows) &&
                        !(i_in_item.left_edge == 8'd0 ||
                          i_in_item.right_edge == EDGE_RIGHT_MAX ||
                          i_in_item.left_edge >= i_in_item.right_edge) &&
                        lane_mid <= r_left_lane_limit) begin
                        n_left_chosen = 1'b1;
                    end
                end
            end
            // poll tick: divided sampling of the range sensor
            KIND_POLL: begin
                if (r_ready_flag) begin
                    n_poll_count = poll_inc;
                    if (poll_inc >= r_poll_divide) begin
                        n_poll_count = '0;
                        sample       = 1'b1;
                        if (!i_in_item.comm_ok) begin
                            // link failure
                            n_no_data_count = '0;
                            if (r_comm_err_count < r_comm_error_limit)
                                n_comm_err_count = r_comm_err_count + 8'd1;
                            n_valid_flag    = 1'b0;
                            n_held_distance = NO_DIST;
                            if (n_comm_err_count >= r_comm_error_limit) reinit = 1'b1;
                        end else begin
                            n_comm_err_count = '0;
                            if (!i_in_item.data_ready) begin
                                // no new measurement
                                if (r_no_data_count < r_no_data_limit)
                                    n_no_data_count = r_no_data_count + 8'd1;
                                if (n_no_data_count >= r_no_data_limit) reinit = 1'b1;
                            end else begin
                                n_no_data_count = '0;
                                if (!i_in_item.range_done ||
                                    i_in_item.range_mm > MAX_DIST) begin
                                    n_valid_flag    = 1'b0;
                                    n_held_distance = NO_DIST;
                                end else begin
                                    n_valid_flag    = 1'b1;
                                    n_held_distance = i_in_item.range_mm[13:0];
                                    if (in_window) begin
                                        n_exit_count  = '0;
                                        n_enter_count = '0;
                                        if (!r_avoid_mode) begin
                                            // count toward entering avoid
                                            n_enter_count = r_enter_count;
                                            if (r_enter_count < r_enter_samples)
                                                n_enter_count = r_enter_count + 8'd1;
                                            if (n_enter_count >= r_enter_samples) begin
                                                n_enter_count = '0;
                                                bias   = r_left_chosen ? BIAS_POS : BIAS_NEG;
                                                bias_w = 1'b1;
                                                if (!i_in_item.motor_stopped) motor = MOTOR_CAP;
                                                n_avoid_mode = 1'b1;
                                            end
                                        end
                                    end else if (r_avoid_mode) begin
                                        // count toward leaving avoid
                                        n_enter_count = '0;
                                        if (r_exit_count < r_exit_samples)
                                            n_exit_count = r_exit_count + 8'd1;
                                        if (n_exit_count >= r_exit_samples) begin
                                            n_exit_count = '0;
                                            bias_w       = 1'b1;
                                            if (!i_in_item.motor_stopped) motor = MOTOR_NORMAL;
                                            n_avoid_mode = 1'b0;
                                        end
                                    end else begin
                                        n_enter_count = '0;
                                        n_exit_count  = '0;
                                    end
                                end
                            end
                        end
                        // sensor reinit request
                        if (reinit) begin
                            n_comm_err_count = '0;
                            n_no_data_count  = '0;
                            n_enter_count    = '0;
                            n_exit_count     = '0;
                            n_valid_flag     = 1'b0;
                            n_held_distance  = NO_DIST;
                            if (!i_in_item.motor_stopped)
                                motor = n_avoid_mode ? MOTOR_CAP : MOTOR_NORMAL;
                            n_poll_count = r_poll_divide - 8'd1;
                        end
                    end
                end
            end
            default: ;
        endcase

        n_out_item.avoiding       = n_avoid_mode;
        n_out_item.path_bias      = bias;
        n_out_item.bias_written   = bias_w;
        n_out_item.motor_cmd      = motor;
        n_out_item.reinit_request = reinit;
        n_out_item.sample_taken   = sample;
        n_out_item.range_valid    = n_valid_flag;
        n_out_item.last_distance  = n_held_distance;
        n_out_item.bypass_left    = n_left_chosen;
        n_out_item.sensor_ready   = n_ready_flag;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_flag     <= 1'b0;
            r_avoid_mode     <= 1'b0;
            r_left_chosen    <= 1'b0;
            r_valid_flag     <= 1'b0;
            r_poll_count     <= 8'd1;
            r_comm_err_count <= '0;
            r_no_data_count  <= '0;
            r_enter_count    <= '0;
            r_exit_count     <= '0;
            r_held_distance  <= NO_DIST;
        end else if (in_accept) begin
            r_ready_flag     <= n_ready_flag;
            r_avoid_mode     <= n_avoid_mode;
            r_left_chosen    <= n_left_chosen;
            r_valid_flag     <= n_valid_flag;
            r_poll_count     <= n_poll_count;
            r_comm_err_count <= n_comm_err_count;
            r_no_data_count  <= n_no_data_count;
            r_enter_count    <= n_enter_count;
            r_exit_count     <= n_exit_count;
            r_held_distance  <= n_held_distance;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef ASSERT_OFF
    // a held distance always comes with the valid flag
    a_held_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_distance != NO_DIST |-> r_valid_flag)
        else $error("held distance without valid flag");

    // an accepted item always leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // bias is only written on a sensor sample
    a_bias_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.bias_written |-> r_out_item.sample_taken)
        else $error("bias written without a sample");

    // an init item leaves the controller following with no distance
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.kind == KIND_INIT |=> !r_avoid_mode && !r_valid_flag)
        else $error("init item did not clear state");
`endif

endmodule
